// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL, used by the top-level file; clock and reset are i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ACQT_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("acqt assertion failed");

// next-cycle implication
`define ACQT_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("acqt assertion failed");

`endif

// ===== rtl/acqt_pkg.sv =====
// Shared types and constants of the box collision query table.
`default_nettype none

package acqt_pkg;

    localparam int ACQT_NUM_ENTRIES = 32;
    localparam int ACQT_COORD_BITS  = 16;
    localparam int IDX_W            = 5;
    localparam int TAG_W            = 16;
    localparam int OP_W             = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // pipeline token: vld = entry to test (or hit, after evaluation), fin = end of scan
    typedef struct packed {
        logic vld;
        logic fin;
    } t_tok;

endpackage

`default_nettype wire

// ===== rtl/acqt_in_if.sv =====
// Request channel: operation, entry index, box and tag.
`default_nettype none

interface acqt_in_if
    import acqt_pkg::*;
#(
    parameter int COORD_BITS = ACQT_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              operation;
    logic [IDX_W-1:0]             entry_index;
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-2:0]        box_width;
    logic [COORD_BITS-2:0]        box_height;
    logic [TAG_W-1:0]             object_tag;

    modport source (
        output valid, operation, entry_index, box_x, box_y, box_width, box_height,
               object_tag,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, box_x, box_y, box_width, box_height,
               object_tag,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/acqt_out_if.sv =====
// Result channel: hit flag, hit entry, intersection rectangle, last marker.
`default_nettype none

interface acqt_out_if
    import acqt_pkg::*;
#(
    parameter int COORD_BITS = ACQT_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic                         hit_valid;
    logic [IDX_W-1:0]             hit_index;
    logic [TAG_W-1:0]             hit_tag;
    logic signed [COORD_BITS-1:0] overlap_x;
    logic signed [COORD_BITS-1:0] overlap_y;
    logic [COORD_BITS-1:0]        overlap_width;
    logic [COORD_BITS-1:0]        overlap_height;
    logic                         last_result;

    modport source (
        output valid, hit_valid, hit_index, hit_tag, overlap_x, overlap_y,
               overlap_width, overlap_height, last_result,
        input  ready
    );
    modport sink (
        input  valid, hit_valid, hit_index, hit_tag, overlap_x, overlap_y,
               overlap_width, overlap_height, last_result,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/aabb_collision_query_table_top.sv =====
// Top level of the box collision query table: control, valid bits, hit holding and output.
//
//  channel  dir  beat contents
//  i_in     in   operation, entry_index, box_x, box_y, box_width, box_height, object_tag
//  o_out    out  hit_valid, hit_index, hit_tag, overlap_x/y/width/height, last_result
//
// Write, clear, no-op and a query of an invalid or out-of-range entry answer with one beat.
// Query: the box table has one read port and the scan reads one entry per cycle while o_out
// does not stall (query box read, then entries 0 to NUM_ENTRIES-1).
// A hit is held back one beat so that the last one can be marked; o_out stalls freeze
// the whole scan pipeline.
// Reset clears valid bits and control; box and tag contents are undefined until written.
`default_nettype none
`include "assert_macros.svh"

module aabb_collision_query_table_top
    import acqt_pkg::*;
#(
    parameter int NUM_ENTRIES = ACQT_NUM_ENTRIES,
    parameter int COORD_BITS  = ACQT_COORD_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    acqt_in_if.sink    i_in,
    acqt_out_if.source o_out
);

    localparam int C      = COORD_BITS;
    localparam int AW     = $clog2(NUM_ENTRIES);
    localparam int CW     = $clog2(NUM_ENTRIES + 1);
    localparam int BOX_W  = 4 * C - 2;
    localparam int WORD_W = BOX_W + TAG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QLOAD,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state              r_state;
    logic [NUM_ENTRIES-1:0] r_valid;
    logic [CW-1:0]       r_scan_cnt;
    logic [AW-1:0]       r_q_idx;
    logic signed [C-1:0] r_qx, r_qy;
    logic [C-2:0]        r_qw, r_qh;

    t_tok                r_rd_tok;
    logic [AW-1:0]       r_rd_idx;

    logic                r_pd_vld;
    logic [IDX_W-1:0]    r_pd_idx;
    logic [TAG_W-1:0]    r_pd_tag;
    logic signed [C-1:0] r_pd_x, r_pd_y;
    logic [C-1:0]        r_pd_w, r_pd_h;

    logic                r_out_vld;
    logic                r_out_hit;
    logic [IDX_W-1:0]    r_out_idx;
    logic [TAG_W-1:0]    r_out_tag;
    logic signed [C-1:0] r_out_x, r_out_y;
    logic [C-1:0]        r_out_w, r_out_h;
    logic                r_out_last;
    logic                n_out_vld;

    logic                adv;
    logic                in_acc;
    t_op                 op;
    logic                in_range;
    logic [AW-1:0]       addr_in;
    logic                q_ok;
    logic                scan_more;
    logic [AW-1:0]       scan_addr;

    logic                mem_wr_en;
    logic [WORD_W-1:0]   mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [WORD_W-1:0]   mem_rd_data;

    logic signed [C-1:0] ent_x, ent_y;
    logic [C-2:0]        ent_w, ent_h;
    logic [TAG_W-1:0]    ent_tag;

    t_tok                ev_tok;
    logic [AW-1:0]       ev_idx;
    logic [TAG_W-1:0]    ev_tag;
    logic signed [C-1:0] ev_lx, ev_ty;
    logic signed [C:0]   ev_rx, ev_by;
    logic signed [C:0]   ev_w, ev_h;

    // pipeline moves whenever the output register is free or being drained
    assign adv       = !r_out_vld || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && adv;
    assign in_acc    = i_in.valid && i_in.ready;
    assign op        = t_op'(i_in.operation);
    assign in_range  = 32'(i_in.entry_index) < NUM_ENTRIES;
    assign addr_in   = AW'(i_in.entry_index);
    assign q_ok      = (op == OP_QUERY) && in_range && r_valid[addr_in];
    assign scan_more = r_scan_cnt < CW'(NUM_ENTRIES);
    assign scan_addr = r_scan_cnt[AW-1:0];

    // a beat is loaded for an empty reply, a flushed hit, or the end of a scan
    assign n_out_vld = adv ? ((in_acc && !q_ok) || (ev_tok.vld && r_pd_vld) || ev_tok.fin)
                           : r_out_vld;

    assign mem_wr_en   = in_acc && (op == OP_WRITE) && in_range;
    assign mem_wr_data = {i_in.object_tag, i_in.box_height, i_in.box_width,
                          i_in.box_y, i_in.box_x};
    assign mem_rd_en   = (r_state == S_IDLE) || ((r_state == S_SCAN) && adv && scan_more);
    assign mem_rd_addr = (r_state == S_IDLE) ? addr_in : scan_addr;

    assign ent_x   = mem_rd_data[C-1:0];
    assign ent_y   = mem_rd_data[2*C-1:C];
    assign ent_w   = mem_rd_data[3*C-2:2*C];
    assign ent_h   = mem_rd_data[BOX_W-1:3*C-1];
    assign ent_tag = mem_rd_data[WORD_W-1:BOX_W];

    assign ev_w = ev_rx - $signed({ev_lx[C-1], ev_lx});
    assign ev_h = ev_by - $signed({ev_ty[C-1], ev_ty});

    acqt_mem #(
        .DEPTH (NUM_ENTRIES),
        .WIDTH (WORD_W),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (addr_in),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    acqt_ovl #(
        .COORD_BITS (C),
        .AW         (AW)
    ) u_ovl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tok   (r_rd_tok),
        .i_idx   (r_rd_idx),
        .i_ax    (r_qx),
        .i_ay    (r_qy),
        .i_aw    (r_qw),
        .i_ah    (r_qh),
        .i_bx    (ent_x),
        .i_by    (ent_y),
        .i_bw    (ent_w),
        .i_bh    (ent_h),
        .i_btag  (ent_tag),
        .o_tok   (ev_tok),
        .o_idx   (ev_idx),
        .o_tag   (ev_tag),
        .o_lx    (ev_lx),
        .o_ty    (ev_ty),
        .o_rx    (ev_rx),
        .o_by    (ev_by)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_scan_cnt <= '0;
            r_rd_tok   <= '0;
            r_pd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (op)
                            OP_WRITE: if (in_range) r_valid[addr_in] <= 1'b1;
                            OP_CLEAR: if (in_range) r_valid[addr_in] <= 1'b0;
                            OP_QUERY: ;
                            OP_NOP:   ;
                        endcase
                        if (q_ok) begin
                            r_state    <= S_QLOAD;
                            r_q_idx    <= addr_in;
                            r_scan_cnt <= '0;
                        end else begin
                            r_out_hit  <= 1'b0;
                            r_out_idx  <= '0;
                            r_out_tag  <= '0;
                            r_out_x    <= '0;
                            r_out_y    <= '0;
                            r_out_w    <= '0;
                            r_out_h    <= '0;
                            r_out_last <= 1'b1;
                        end
                    end
                end
                S_QLOAD: begin
                    r_qx    <= ent_x;
                    r_qy    <= ent_y;
                    r_qw    <= ent_w;
                    r_qh    <= ent_h;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (adv) begin
                        if (scan_more) begin
                            r_rd_tok.vld <= r_valid[scan_addr] && (scan_addr != r_q_idx);
                            r_rd_tok.fin <= 1'b0;
                            r_rd_idx     <= scan_addr;
                            r_scan_cnt   <= r_scan_cnt + 1'b1;
                        end else begin
                            // end-of-scan marker follows the last entry
                            r_rd_tok.vld <= 1'b0;
                            r_rd_tok.fin <= 1'b1;
                            r_state      <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (adv) begin
                        r_rd_tok <= '0;
                        if (ev_tok.fin) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase

            // hold one hit back so the final beat can carry last_result
            if (adv) begin
                if (ev_tok.vld) begin
                    if (r_pd_vld) begin
                        r_out_hit  <= 1'b1;
                        r_out_idx  <= r_pd_idx;
                        r_out_tag  <= r_pd_tag;
                        r_out_x    <= r_pd_x;
                        r_out_y    <= r_pd_y;
                        r_out_w    <= r_pd_w;
                        r_out_h    <= r_pd_h;
                        r_out_last <= 1'b0;
                    end
                    r_pd_vld <= 1'b1;
                    r_pd_idx <= IDX_W'(ev_idx);
                    r_pd_tag <= ev_tag;
                    r_pd_x   <= ev_lx;
                    r_pd_y   <= ev_ty;
                    r_pd_w   <= ev_w[C-1:0];
                    r_pd_h   <= ev_h[C-1:0];
                end else if (ev_tok.fin) begin
                    r_out_hit  <= r_pd_vld;
                    r_out_idx  <= r_pd_vld ? r_pd_idx : '0;
                    r_out_tag  <= r_pd_vld ? r_pd_tag : '0;
                    r_out_x    <= r_pd_vld ? r_pd_x : '0;
                    r_out_y    <= r_pd_vld ? r_pd_y : '0;
                    r_out_w    <= r_pd_vld ? r_pd_w : '0;
                    r_out_h    <= r_pd_vld ? r_pd_h : '0;
                    r_out_last <= 1'b1;
                    r_pd_vld   <= 1'b0;
                end
            end
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.hit_valid      = r_out_hit;
    assign o_out.hit_index      = r_out_idx;
    assign o_out.hit_tag        = r_out_tag;
    assign o_out.overlap_x      = r_out_x;
    assign o_out.overlap_y      = r_out_y;
    assign o_out.overlap_width  = r_out_w;
    assign o_out.overlap_height = r_out_h;
    assign o_out.last_result    = r_out_last;

    `ACQT_ASSERT_IMPL(a_pend_in_scan, r_pd_vld, (r_state == S_SCAN) || (r_state == S_DRAIN))
    `ACQT_ASSERT_IMPL(a_fin_in_drain, ev_tok.fin, r_state == S_DRAIN)
    `ACQT_ASSERT_IMPL(a_cnt_bound, 1'b1, r_scan_cnt <= CW'(NUM_ENTRIES))
    `ACQT_ASSERT_IMPL(a_empty_is_last, r_out_vld && !r_out_hit, r_out_last)
    `ACQT_ASSERT_NEXT(a_hit_flush, adv && ev_tok.vld && r_pd_vld,
                      r_out_vld && r_out_hit && !r_out_last)

endmodule

`default_nettype wire

// ===== rtl/acqt_mem.sv =====
// Single-port-write, registered-read memory holding box and tag of each entry.
`default_nettype none

module acqt_mem
    import acqt_pkg::*;
#(
    parameter int DEPTH = ACQT_NUM_ENTRIES,
    parameter int WIDTH = 4 * ACQT_COORD_BITS - 2 + TAG_W,
    parameter int AW    = $clog2(ACQT_NUM_ENTRIES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/acqt_ovl.sv =====
// Overlap evaluation stage: strict edge tests and intersection edges, registered.
`default_nettype none

module acqt_ovl
    import acqt_pkg::*;
#(
    parameter int COORD_BITS = ACQT_COORD_BITS,
    parameter int AW         = $clog2(ACQT_NUM_ENTRIES)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_adv,
    input  wire t_tok                         i_tok,
    input  wire logic [AW-1:0]                i_idx,
    input  wire logic signed [COORD_BITS-1:0] i_ax,
    input  wire logic signed [COORD_BITS-1:0] i_ay,
    input  wire logic [COORD_BITS-2:0]        i_aw,
    input  wire logic [COORD_BITS-2:0]        i_ah,
    input  wire logic signed [COORD_BITS-1:0] i_bx,
    input  wire logic signed [COORD_BITS-1:0] i_by,
    input  wire logic [COORD_BITS-2:0]        i_bw,
    input  wire logic [COORD_BITS-2:0]        i_bh,
    input  wire logic [TAG_W-1:0]             i_btag,
    output t_tok                              o_tok,
    output logic [AW-1:0]                     o_idx,
    output logic [TAG_W-1:0]                  o_tag,
    output logic signed [COORD_BITS-1:0]      o_lx,
    output logic signed [COORD_BITS-1:0]      o_ty,
    output logic signed [COORD_BITS:0]        o_rx,
    output logic signed [COORD_BITS:0]        o_by
);

    localparam int C = COORD_BITS;

    logic signed [C:0]   ax_e, ay_e, bx_e, by_e;
    logic signed [C:0]   ar, ab, br, bb;
    logic                hit;
    logic signed [C-1:0] lx, ty;
    logic signed [C:0]   rx, by_min;

    t_tok                r_tok;
    logic [AW-1:0]       r_idx;
    logic [TAG_W-1:0]    r_tag;
    logic signed [C-1:0] r_lx, r_ty;
    logic signed [C:0]   r_rx, r_by;

    always_comb begin
        ax_e = $signed({i_ax[C-1], i_ax});
        ay_e = $signed({i_ay[C-1], i_ay});
        bx_e = $signed({i_bx[C-1], i_bx});
        by_e = $signed({i_by[C-1], i_by});
        ar   = ax_e + $signed({2'b00, i_aw});
        ab   = ay_e + $signed({2'b00, i_ah});
        br   = bx_e + $signed({2'b00, i_bw});
        bb   = by_e + $signed({2'b00, i_bh});
        // touching edges are not an overlap
        hit  = i_tok.vld && (ab > by_e) && (ay_e < bb) && (ar > bx_e) && (ax_e < br);
        lx     = (i_ax > i_bx) ? i_ax : i_bx;
        ty     = (i_ay > i_by) ? i_ay : i_by;
        rx     = (ar < br) ? ar : br;
        by_min = (ab < bb) ? ab : bb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok.vld <= hit;
            r_tok.fin <= i_tok.fin;
            r_idx     <= i_idx;
            r_tag     <= i_btag;
            r_lx      <= lx;
            r_ty      <= ty;
            r_rx      <= rx;
            r_by      <= by_min;
        end
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;
    assign o_tag = r_tag;
    assign o_lx  = r_lx;
    assign o_ty  = r_ty;
    assign o_rx  = r_rx;
    assign o_by  = r_by;

endmodule

`default_nettype wire
